FILE: rtl/lifo_stack_with_search_unit_assert.svh
// Assertion macros shared by the stack checker.
`ifndef LIFO_STACK_WITH_SEARCH_UNIT_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lifo stack check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lifo stack check failed");

`endif

FILE: rtl/lss_pkg.sv
// Package: widths, command and status codes of the search stack.
`default_nettype none

package lss_pkg;

  localparam int unsigned Depth   = 256;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned CntW    = 9;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 8;

  localparam logic [CmdW-1:0] CmdPush      = 3'd0;
  localparam logic [CmdW-1:0] CmdPop       = 3'd1;
  localparam logic [CmdW-1:0] CmdOverwrite = 3'd2;
  localparam logic [CmdW-1:0] CmdSearch    = 3'd3;
  localparam logic [CmdW-1:0] CmdClear     = 3'd4;

  localparam logic [StatusW-1:0] StDone  = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/lss_if.sv
// Channel interfaces: command words in, result words out.
`default_nettype none

interface lss_in_if;
  logic                               valid;
  logic                               ready;
  logic        [lss_pkg::CmdW-1:0]    cmd;
  logic signed [lss_pkg::ValW-1:0]    value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface lss_out_if;
  logic                                valid;
  logic                                ready;
  logic        [lss_pkg::StatusW-1:0]  status;
  logic signed [lss_pkg::ValW-1:0]     popped_value;
  logic signed [lss_pkg::ValW-1:0]     top_value;
  logic                                found;
  logic        [lss_pkg::PosW-1:0]     position;
  logic        [lss_pkg::CntW-1:0]     count;
  logic                                is_empty;

  modport source (output valid, output status, output popped_value, output top_value,
                  output found, output position, output count, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input popped_value, input top_value,
                  input found, input position, input count, input is_empty,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/lss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/lifo_stack_with_search_unit.sv
// Push, overwrite, clear and query go from accept straight to the done state;
// pop does too for the last entry, else it reads the new top back from the RAM.
// Search walks down from the top entry until a match or the bottom entry;
// the scan reads one entry per cycle through the RAM port.
// One word in flight: in ready is high only while the sequencer is idle.
// Reset clears the entry count and the handshake state; entries stay undefined.
`default_nettype none

module lifo_stack_with_search_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lss_in_if.sink    in_i,
  lss_out_if.source out_o
);

  // Sequencer states
  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SPopRd  = 3'd1;
  localparam logic [2:0] SPopCap = 3'd2;
  localparam logic [2:0] SSrch   = 3'd3;
  localparam logic [2:0] SDone   = 3'd4;

  logic [2:0] state_q, state_d;

  // Stack bookkeeping: entry count and a cached copy of the top entry
  logic [lss_pkg::CntW-1:0]  count_q, count_d;
  logic [lss_pkg::ValW-1:0]  top_q, top_d;

  // Scan / read-back address and search key
  logic [lss_pkg::AddrW-1:0] addr_q, addr_d;
  logic [lss_pkg::AddrW-1:0] scan_q, scan_d;
  logic                      vld_q, vld_d;
  logic [lss_pkg::ValW-1:0]  key_q, key_d;

  // Pending result fields
  logic [lss_pkg::StatusW-1:0] res_status_q, res_status_d;
  logic [lss_pkg::ValW-1:0]    res_popped_q, res_popped_d;
  logic                        res_found_q, res_found_d;
  logic [lss_pkg::AddrW-1:0]   res_pos_q, res_pos_d;

  // Output register
  logic                        out_valid_q, out_valid_d;
  logic                        out_load;
  logic [lss_pkg::StatusW-1:0] out_status_q;
  logic [lss_pkg::ValW-1:0]    out_popped_q;
  logic [lss_pkg::ValW-1:0]    out_top_q;
  logic                        out_found_q;
  logic [lss_pkg::PosW-1:0]    out_pos_q;
  logic [lss_pkg::CntW-1:0]    out_count_q;
  logic                        out_empty_q;

  // RAM write port and read data
  logic                      ram_we;
  logic [lss_pkg::AddrW-1:0] ram_waddr;
  logic [lss_pkg::ValW-1:0]  ram_rdata;

  logic in_fire;
  logic full;
  logic empty;
  logic hit;
  logic last;

  assign in_i.ready = (state_q == SIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign full       = (count_q == lss_pkg::CntW'(lss_pkg::Depth));
  assign empty      = (count_q == '0);

  // Compare unit: key against the word read out of the RAM
  assign hit  = vld_q && (ram_rdata == key_q);
  assign last = vld_q && (lss_pkg::CntW'(scan_q) == (count_q - lss_pkg::CntW'(1)));

  assign out_load = (state_q == SDone) && (!out_valid_q || out_o.ready);

  lss_ram #(
    .Width(lss_pkg::ValW),
    .Depth(lss_pkg::Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_i.value),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    top_d        = top_q;
    addr_d       = addr_q;
    scan_d       = scan_q;
    vld_d        = vld_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_popped_d = res_popped_q;
    res_found_d  = res_found_q;
    res_pos_d    = res_pos_q;
    ram_we       = 1'b0;
    ram_waddr    = lss_pkg::AddrW'(count_q);

    case (state_q)
      SIdle: begin
        if (in_fire) begin
          res_status_d = lss_pkg::StDone;
          res_popped_d = '0;
          res_found_d  = 1'b0;
          res_pos_d    = '0;
          state_d      = SDone;
          case (in_i.cmd)
            lss_pkg::CmdPush: begin
              if (full) begin
                res_status_d = lss_pkg::StFull;
              end else begin
                // Write at the current count, bump the count, cache the new top
                ram_we    = 1'b1;
                ram_waddr = lss_pkg::AddrW'(count_q);
                top_d     = in_i.value;
                count_d   = count_q + lss_pkg::CntW'(1);
              end
            end
            lss_pkg::CmdPop: begin
              if (empty) begin
                res_status_d = lss_pkg::StEmpty;
              end else begin
                res_popped_d = top_q;
                count_d      = count_q - lss_pkg::CntW'(1);
                // Fetch the entry below the old top unless the stack drains
                if (count_q != lss_pkg::CntW'(1)) begin
                  addr_d  = lss_pkg::AddrW'(count_q - lss_pkg::CntW'(2));
                  state_d = SPopRd;
                end
              end
            end
            lss_pkg::CmdOverwrite: begin
              if (empty) begin
                res_status_d = lss_pkg::StEmpty;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = lss_pkg::AddrW'(count_q - lss_pkg::CntW'(1));
                top_d     = in_i.value;
              end
            end
            lss_pkg::CmdSearch: begin
              if (!empty) begin
                // Start the walk at the top entry
                key_d   = in_i.value;
                addr_d  = lss_pkg::AddrW'(count_q - lss_pkg::CntW'(1));
                scan_d  = '0;
                vld_d   = 1'b0;
                state_d = SSrch;
              end
            end
            lss_pkg::CmdClear: begin
              count_d = '0;
            end
            default: begin
              // Query and unused codes: report only
            end
          endcase
        end
      end
      SPopRd: begin
        // RAM samples addr_q at the end of this cycle
        state_d = SPopCap;
      end
      SPopCap: begin
        top_d   = ram_rdata;
        state_d = SDone;
      end
      SSrch: begin
        if (hit) begin
          res_found_d = 1'b1;
          res_pos_d   = scan_q;
          state_d     = SDone;
        end else if (last) begin
          state_d = SDone;
        end else begin
          // Advance one entry down; the word on ram_rdata belongs to scan_q
          addr_d = addr_q - lss_pkg::AddrW'(1);
          scan_d = vld_q ? (scan_q + lss_pkg::AddrW'(1)) : '0;
          vld_d  = 1'b1;
        end
      end
      SDone: begin
        if (out_load) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    top_q        <= top_d;
    addr_q       <= addr_d;
    scan_q       <= scan_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_popped_q <= res_popped_d;
    res_found_q  <= res_found_d;
    res_pos_q    <= res_pos_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_popped_q <= res_popped_q;
      out_top_q    <= empty ? '0 : top_q;
      out_found_q  <= res_found_q;
      out_pos_q    <= lss_pkg::PosW'(res_pos_q);
      out_count_q  <= count_q;
      out_empty_q  <= empty;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.popped_value = out_popped_q;
  assign out_o.top_value    = out_top_q;
  assign out_o.found        = out_found_q;
  assign out_o.position     = out_pos_q;
  assign out_o.count        = out_count_q;
  assign out_o.is_empty     = out_empty_q;

endmodule

`default_nettype wire

FILE: rtl/lss_checker.sv
// Port-level checker for the search stack, bound to the top level.
`default_nettype none

`include "lifo_stack_with_search_unit_assert.svh"

module lss_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [lss_pkg::StatusW-1:0] status_i,
  input wire logic [lss_pkg::ValW-1:0]    popped_value_i,
  input wire logic [lss_pkg::ValW-1:0]    top_value_i,
  input wire logic                        found_i,
  input wire logic [lss_pkg::PosW-1:0]    position_i,
  input wire logic [lss_pkg::CntW-1:0]    count_i,
  input wire logic                        is_empty_i
);

  // Hold a stalled result word
  `LSS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(top_value_i) && $stable(count_i))

  // Empty flag, count and top value agree
  `LSS_ASSERT_NOW(a_empty_cnt, out_valid_i, is_empty_i == (count_i == '0) && (!is_empty_i || top_value_i == '0))

  // A refused command moves no value out
  `LSS_ASSERT_NOW(a_refused, out_valid_i && status_i != lss_pkg::StDone, popped_value_i == '0 && !found_i)

  // A miss reports position zero
  `LSS_ASSERT_NOW(a_miss_pos, out_valid_i && !found_i, position_i == '0)

endmodule

bind lifo_stack_with_search_unit lss_checker u_lss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .popped_value_i(out_o.popped_value),
  .top_value_i   (out_o.top_value),
  .found_i       (out_o.found),
  .position_i    (out_o.position),
  .count_i       (out_o.count),
  .is_empty_i    (out_o.is_empty)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the search stack: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module testbench;
  import lss_pkg::*;

  // Codes with no name in the package: query, plus the two spare codes that act as query.
  localparam logic [CmdW-1:0] CmdQuery  = 3'd5;
  localparam logic [CmdW-1:0] CmdSpare6 = 3'd6;
  localparam logic [CmdW-1:0] CmdSpare7 = 3'd7;

  localparam int unsigned HoldOffCycles = 400;

  // One result word, field for field as it leaves the block.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValW-1:0]    popped_value;
    logic [ValW-1:0]    top_value;
    logic               found;
    logic [PosW-1:0]    position;
    logic [CntW-1:0]    count;
    logic               is_empty;
  } stack_result_t;

  // One row of the directed table; want is used only when pinned is set.
  typedef struct {
    logic [CmdW-1:0] cmd;
    logic [ValW-1:0] value;
    bit              pinned;
    stack_result_t   want;
  } stack_row_t;

  logic clk_i;
  logic rst_ni;

  lss_in_if  in_if ();
  lss_out_if out_if ();

  lifo_stack_with_search_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the stack: entries and fill level.
  logic [ValW-1:0] stack_mem [Depth];
  int unsigned     stack_fill;

  stack_result_t expected_results [$];
  int unsigned   error_count;
  int unsigned   src_idle_pct;
  int unsigned   snk_idle_pct;
  bit            hold_off_req;

  // Apply one command to the shadow stack and return the result word it must produce.
  function automatic stack_result_t apply_stack_op(logic [CmdW-1:0] op, logic [ValW-1:0] v);
    stack_result_t r;
    r = '0;
    r.status = StDone;
    case (op)
      CmdPush: begin
        if (stack_fill >= Depth) begin
          r.status = StFull;
        end else begin
          stack_mem[stack_fill] = v;
          stack_fill++;
        end
      end
      CmdPop: begin
        if (stack_fill == 0) begin
          r.status = StEmpty;
        end else begin
          stack_fill--;
          r.popped_value = stack_mem[stack_fill];
        end
      end
      CmdOverwrite: begin
        if (stack_fill == 0) begin
          r.status = StEmpty;
        end else begin
          stack_mem[stack_fill - 1] = v;
        end
      end
      CmdSearch: begin
        // Walk down from the top; the topmost match wins.
        for (int unsigned d = 0; d < stack_fill; d++) begin
          if (stack_mem[stack_fill - 1 - d] == v) begin
            r.found    = 1'b1;
            r.position = PosW'(d);
            break;
          end
        end
      end
      CmdClear: begin
        stack_fill = 0;
      end
      default: begin
      end
    endcase
    r.top_value = (stack_fill == 0) ? '0 : stack_mem[stack_fill - 1];
    r.count     = CntW'(stack_fill);
    r.is_empty  = (stack_fill == 0);
    return r;
  endfunction

  // Mostly plain random values; now and then a corner value so that duplicates show up.
  function automatic logic [ValW-1:0] fresh_value();
    if ($urandom_range(99) >= 20) return $urandom;
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hffff_ffff;
      3: return 32'h8000_0000;
      4: return 32'h7fff_ffff;
      default: return 32'h5a5a_5a5a;
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic [ValW-1:0] got, logic [ValW-1:0] want);
    error_count++;
    $display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
  endtask

  // Offer one command word. Call at a rising edge; returns at the edge that accepts it.
  task automatic offer_word(input logic [CmdW-1:0] op, input logic [ValW-1:0] v,
                            input bit pinned = 1'b0, input stack_result_t want = '0);
    stack_result_t predicted;
    // Idle for a random number of cycles, valid low.
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= op;
    in_if.value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = apply_stack_op(op, v);
    expected_results.push_back(pinned ? want : predicted);
  endtask

  // Drop valid and hold until every outstanding result word has come back.
  task automatic pause_sender();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Random command drawn against the current shadow state; searches mostly hit a held entry.
  task automatic pick_stack_op(output logic [CmdW-1:0] op, output logic [ValW-1:0] v);
    int unsigned roll;
    roll = $urandom_range(99);
    if      (roll < 30) op = CmdPush;
    else if (roll < 52) op = CmdPop;
    else if (roll < 62) op = CmdOverwrite;
    else if (roll < 84) op = CmdSearch;
    else if (roll < 87) op = CmdClear;
    else if (roll < 95) op = CmdQuery;
    else if (roll < 97) op = CmdSpare6;
    else                op = CmdSpare7;
    v = fresh_value();
    if (op == CmdSearch && stack_fill != 0 && $urandom_range(9) < 7) begin
      v = stack_mem[$urandom_range(stack_fill - 1)];
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(posedge clk_i);
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Scoreboard: compare every accepted result word with the oldest expectation.
  initial begin
    stack_result_t got;
    stack_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.status       = out_if.status;
        got.popped_value = out_if.popped_value;
        got.top_value    = out_if.top_value;
        got.found        = out_if.found;
        got.position     = out_if.position;
        got.count        = out_if.count;
        got.is_empty     = out_if.is_empty;
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result word", got.top_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            flag_mismatch("status", ValW'(got.status), ValW'(want.status));
          if (got.popped_value !== want.popped_value)
            flag_mismatch("popped_value", got.popped_value, want.popped_value);
          if (got.top_value !== want.top_value)
            flag_mismatch("top_value", got.top_value, want.top_value);
          if (got.found !== want.found)
            flag_mismatch("found", ValW'(got.found), ValW'(want.found));
          if (got.position !== want.position)
            flag_mismatch("position", ValW'(got.position), ValW'(want.position));
          if (got.count !== want.count)
            flag_mismatch("count", ValW'(got.count), ValW'(want.count));
          if (got.is_empty !== want.is_empty)
            flag_mismatch("is_empty", ValW'(got.is_empty), ValW'(want.is_empty));
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run (full-depth scans with long stalls).
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus sequencer.
  initial begin
    stack_row_t      directed_rows [$];
    logic [CmdW-1:0] op;
    logic [ValW-1:0] v;

    // Known values on every input from time zero.
    in_if.valid  = 1'b0;
    in_if.cmd    = CmdQuery;
    in_if.value  = '0;
    rst_ni       = 1'b0;
    error_count  = 0;
    hold_off_req = 1'b0;
    stack_fill   = 0;
    src_idle_pct = 36;
    snk_idle_pct = 65;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Pinned rows carry a result that can be read straight off the spec;
    // the rest are left to the shadow stack.
    // Empty stack right after reset: query, then pop, overwrite and search all refused or missed.
    directed_rows.push_back('{CmdQuery, 32'h0, 1'b1, '{StDone, 32'h0, 32'h0, 1'b0, 8'd0, 9'd0, 1'b1}});
    directed_rows.push_back('{CmdPop, 32'h0, 1'b1, '{StEmpty, 32'h0, 32'h0, 1'b0, 8'd0, 9'd0, 1'b1}});
    directed_rows.push_back('{CmdOverwrite, 32'h5, 1'b1,
                              '{StEmpty, 32'h0, 32'h0, 1'b0, 8'd0, 9'd0, 1'b1}});
    directed_rows.push_back('{CmdSearch, 32'h0, 1'b1, '{StDone, 32'h0, 32'h0, 1'b0, 8'd0, 9'd0, 1'b1}});
    // Extremes of the value field.
    directed_rows.push_back('{CmdPush, 32'h7fff_ffff, 1'b1,
                              '{StDone, 32'h0, 32'h7fff_ffff, 1'b0, 8'd0, 9'd1, 1'b0}});
    directed_rows.push_back('{CmdPush, 32'h8000_0000, 1'b1,
                              '{StDone, 32'h0, 32'h8000_0000, 1'b0, 8'd0, 9'd2, 1'b0}});
    directed_rows.push_back('{CmdPush, 32'hffff_ffff, 1'b1,
                              '{StDone, 32'h0, 32'hffff_ffff, 1'b0, 8'd0, 9'd3, 1'b0}});
    directed_rows.push_back('{CmdPush, 32'h0, 1'b0, '0});
    // Search hits at the bottom, in the middle, at the top, and a miss.
    directed_rows.push_back('{CmdSearch, 32'h7fff_ffff, 1'b1,
                              '{StDone, 32'h0, 32'h0, 1'b1, 8'd3, 9'd4, 1'b0}});
    directed_rows.push_back('{CmdSearch, 32'h8000_0000, 1'b0, '0});
    directed_rows.push_back('{CmdSearch, 32'h0, 1'b0, '0});
    directed_rows.push_back('{CmdSearch, 32'h1234_5678, 1'b0, '0});
    directed_rows.push_back('{CmdOverwrite, 32'h5555_5555, 1'b0, '0});
    directed_rows.push_back('{CmdPop, 32'h0, 1'b0, '0});
    // Spare codes behave as query.
    directed_rows.push_back('{CmdSpare6, 32'hdead_beef, 1'b0, '0});
    directed_rows.push_back('{CmdSpare7, 32'h0bad_f00d, 1'b0, '0});
    directed_rows.push_back('{CmdQuery, 32'hffff_ffff, 1'b0, '0});
    // Clear, then make sure stale words are neither popped nor found.
    directed_rows.push_back('{CmdClear, 32'h0, 1'b1, '{StDone, 32'h0, 32'h0, 1'b0, 8'd0, 9'd0, 1'b1}});
    directed_rows.push_back('{CmdPop, 32'h0, 1'b1, '{StEmpty, 32'h0, 32'h0, 1'b0, 8'd0, 9'd0, 1'b1}});
    directed_rows.push_back('{CmdSearch, 32'hffff_ffff, 1'b1,
                              '{StDone, 32'h0, 32'h0, 1'b0, 8'd0, 9'd0, 1'b1}});
    // Duplicates: the topmost copy decides the position.
    directed_rows.push_back('{CmdPush, 32'haaaa_aaaa, 1'b0, '0});
    directed_rows.push_back('{CmdPush, 32'haaaa_aaaa, 1'b0, '0});
    directed_rows.push_back('{CmdPush, 32'h1, 1'b0, '0});
    directed_rows.push_back('{CmdSearch, 32'haaaa_aaaa, 1'b0, '0});
    // Pop down to empty, the last one taking the final entry.
    directed_rows.push_back('{CmdPop, 32'h0, 1'b0, '0});
    directed_rows.push_back('{CmdPop, 32'h0, 1'b0, '0});
    directed_rows.push_back('{CmdPop, 32'h0, 1'b0, '0});

    foreach (directed_rows[k]) begin
      offer_word(directed_rows[k].cmd, directed_rows[k].value,
                 directed_rows[k].pinned, directed_rows[k].want);
    end
    pause_sender();

    // Sender idles lightly, receiver heavily. Midway, hold the receiver off for a long
    // stretch while words keep coming, so the block backs up and stalls its input.
    for (int unsigned n = 0; n < 250; n++) begin
      if (n == 100) hold_off_req = 1'b1;
      pick_stack_op(op, v);
      offer_word(op, v);
    end
    pause_sender();

    // Swap the idle rates.
    src_idle_pct = 65;
    snk_idle_pct = 36;
    for (int unsigned n = 0; n < 250; n++) begin
      pick_stack_op(op, v);
      offer_word(op, v);
    end
    pause_sender();

    // No idling. Fill to the brim and work the full-stack corners.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    while (stack_fill < Depth) begin
      offer_word(CmdPush, $urandom);
    end
    repeat (3) offer_word(CmdPush, fresh_value());
    offer_word(CmdSearch, stack_mem[0]);
    offer_word(CmdSearch, ~stack_mem[0]);
    offer_word(CmdOverwrite, fresh_value());
    offer_word(CmdQuery, fresh_value());
    offer_word(CmdPop, fresh_value());
    offer_word(CmdPush, fresh_value());
    offer_word(CmdSearch, stack_mem[Depth - 1]);
    offer_word(CmdClear, fresh_value());
    for (int unsigned n = 0; n < 150; n++) begin
      pick_stack_op(op, v);
      offer_word(op, v);
    end

    // Drain, then give a stray word time to show up.
    pause_sender();
    repeat (Depth + 8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      flag_mismatch("missing result words", expected_results.size(), '0);
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
